// ----- design/lns_pkg.sv -----
// Package for the least-utilized node selector.
// Holds the item, result and configuration types, register indexes and the rank compare.
// No dependencies; every other design file depends on it.
package lns_pkg;

    // Identifier width used by the trackers and the compares.
    localparam int NODE_ID_BITS = 16;

    // Widths of the fixed fields.
    localparam int PORT_ID_W = 16;
    localparam int UTIL_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 17;

    typedef logic [NODE_ID_BITS-1:0] id_t;
    typedef logic [UTIL_W-1:0]       util_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOAD_FLOOR      = 3'd0,
        CFG_SKIP_LOCAL      = 3'd1,
        CFG_AVAIL_ONLY      = 3'd2,
        CFG_AVOID_GPU_NODES = 3'd3,
        CFG_LOCAL_NODE_ID   = 3'd4
    } cfg_index_t;

    // One node descriptor.
    typedef struct packed {
        logic [PORT_ID_W-1:0] node_id;
        logic                 node_alive;
        logic                 feasible;
        logic                 available;
        logic                 node_has_gpu;
        logic                 gpu_request;
        util_t                utilization;
        logic                 last;
    } item_t;

    // One selection result.
    typedef struct packed {
        logic [PORT_ID_W-1:0] chosen_node;
        logic                 found;
    } result_t;

    // Register contents seen by the selection logic.
    typedef struct packed {
        util_t                load_floor;
        logic                 skip_local;
        logic                 avail_only;
        logic                 avoid_gpu_nodes;
        logic [PORT_ID_W-1:0] local_node_id;
    } cfg_t;

    // True when candidate (cr, cs, cl, cid) ranks ahead of the held best.
    function automatic logic outranks(
        input logic  cr,
        input util_t cs,
        input logic  cl,
        input id_t   cid,
        input logic  br,
        input util_t bs,
        input logic  bl,
        input id_t   bid
    );
        logic r;
        if (cr != br) begin
            r = cr;
        end else if (cs != bs) begin
            r = (cs < bs);
        end else if (cl != bl) begin
            r = cl;
        end else begin
            r = (cid < bid);
        end
        return r;
    endfunction

endpackage

// ----- design/lns_node_if.sv -----
// Valid/ready channel interfaces for node descriptors and selection results.
// Depends on lns_pkg for the payload types.
interface lns_node_if;
    logic            valid;
    logic            ready;
    lns_pkg::item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface lns_result_if;
    logic             valid;
    logic             ready;
    lns_pkg::result_t result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ----- design/least_utilized_node_selector.sv -----
// Top level of the least-utilized node selector.
// Depends on lns_pkg, lns_node_if, lns_result_if, lns_cfg_regs, lns_tracker, lns_out_reg.
//
//   channel   | dir | handshake         | word
//   node_in   | in  | valid/ready       | item_t: one node descriptor
//   result    | out | valid/ready       | result_t: chosen_node, found
//   cfg       | in  | cfg_we, no ready  | cfg_index, cfg_wdata
//
// One descriptor a cycle unless a closing descriptor waits for a full output
// register; the result of a round passes through the input register, then
// compare-and-merge into the output register.
// rst_n clears the valid flags and the configuration registers; the tracker
// and data registers are not reset and are ignored while their flag is low.
// A stalled result stalls the last descriptor of the next round and the input
// behind it; descriptors ahead of it keep flowing.
module least_utilized_node_selector (
    input  logic                          clk,
    input  logic                          rst_n,
    lns_node_if.sink                      node_in,
    lns_result_if.source                  result,
    input  logic                          cfg_we,
    input  logic [lns_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lns_pkg::CFG_DW-1:0]    cfg_wdata
);
    import lns_pkg::*;

    cfg_t    cfg;
    logic    res_take;
    logic    res_valid;
    result_t res;

    lns_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lns_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (node_in.valid),
        .in_item   (node_in.item),
        .in_ready  (node_in.ready),
        .res_take  (res_take),
        .res_valid (res_valid),
        .res       (res)
    );

    lns_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take),
        .out_valid  (result.valid),
        .out_result (result.result),
        .out_ready  (result.ready)
    );

endmodule

// ----- design/lns_cfg_regs.sv -----
// Configuration register file of the node selector, written through a plain write port.
// Depends on lns_pkg.
module lns_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lns_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lns_pkg::CFG_DW-1:0]       cfg_wdata,
    output lns_pkg::cfg_t                    cfg
);
    import lns_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LOAD_FLOOR:      cfg_next.load_floor      = util_t'(cfg_wdata);
                CFG_SKIP_LOCAL:      cfg_next.skip_local      = cfg_wdata[0];
                CFG_AVAIL_ONLY:      cfg_next.avail_only      = cfg_wdata[0];
                CFG_AVOID_GPU_NODES: cfg_next.avoid_gpu_nodes = cfg_wdata[0];
                CFG_LOCAL_NODE_ID:   cfg_next.local_node_id   = cfg_wdata[PORT_ID_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/lns_tracker.sv -----
// Input register and the two best-node trackers of the node selector.
// Produces one result word when the last descriptor of a round is consumed.
// Depends on lns_pkg.
module lns_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  lns_pkg::cfg_t    cfg,
    input  logic             in_valid,
    input  lns_pkg::item_t   in_item,
    output logic             in_ready,
    input  logic             res_take,
    output logic             res_valid,
    output lns_pkg::result_t res
);
    import lns_pkg::*;

    // Input register
    logic  s1_valid_reg;
    logic  s1_valid_next;
    item_t s1_item_reg;

    // General tracker
    logic  any_valid_reg, any_valid_next;
    id_t   any_id_reg, any_id_next;
    util_t any_score_reg, any_score_next;
    logic  any_ready_reg, any_ready_next;
    logic  any_local_reg, any_local_next;

    // Available non-GPU tracker
    logic  cpu_valid_reg, cpu_valid_next;
    id_t   cpu_id_reg, cpu_id_next;
    util_t cpu_score_reg, cpu_score_next;
    logic  cpu_local_reg, cpu_local_next;

    logic  s1_fire;
    logic  in_fire;
    id_t   cand_id;
    util_t cand_score;
    logic  cand_local;
    logic  competes;
    logic  take_any;
    logic  take_cpu;
    logic  use_cpu;

    // Consume the held word unless it closes a round and the result slot is full
    assign s1_fire  = s1_valid_reg && (!s1_item_reg.last || res_take);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    // Candidate attributes
    assign cand_id    = id_t'(s1_item_reg.node_id);
    assign cand_local = (cand_id == id_t'(cfg.local_node_id));
    assign cand_score = (s1_item_reg.utilization < cfg.load_floor)
                        ? '0 : s1_item_reg.utilization;
    assign competes   = s1_item_reg.node_alive && s1_item_reg.feasible
                        && !(cand_local && cfg.skip_local);

    assign take_any = competes
                      && (s1_item_reg.available || !cfg.avail_only)
                      && (!any_valid_reg
                          || outranks(s1_item_reg.available, cand_score, cand_local, cand_id,
                                      any_ready_reg, any_score_reg, any_local_reg,
                                      any_id_reg));
    assign take_cpu = competes && s1_item_reg.available && !s1_item_reg.node_has_gpu
                      && (!cpu_valid_reg
                          || outranks(1'b1, cand_score, cand_local, cand_id,
                                      1'b1, cpu_score_reg, cpu_local_reg, cpu_id_reg));

    // Merge the candidate into both trackers; drop them after the last word
    always_comb
    begin
        any_valid_next = any_valid_reg;
        any_id_next    = any_id_reg;
        any_score_next = any_score_reg;
        any_ready_next = any_ready_reg;
        any_local_next = any_local_reg;
        cpu_valid_next = cpu_valid_reg;
        cpu_id_next    = cpu_id_reg;
        cpu_score_next = cpu_score_reg;
        cpu_local_next = cpu_local_reg;
        if (s1_fire && take_any)
        begin
            any_valid_next = 1'b1;
            any_id_next    = cand_id;
            any_score_next = cand_score;
            any_ready_next = s1_item_reg.available;
            any_local_next = cand_local;
        end
        if (s1_fire && take_cpu)
        begin
            cpu_valid_next = 1'b1;
            cpu_id_next    = cand_id;
            cpu_score_next = cand_score;
            cpu_local_next = cand_local;
        end
        if (s1_fire && s1_item_reg.last)
        begin
            any_valid_next = 1'b0;
            cpu_valid_next = 1'b0;
        end
    end

    // Pick the round winner from the merged tracker values
    assign use_cpu = cfg.avoid_gpu_nodes && !s1_item_reg.gpu_request
                     && (take_cpu || cpu_valid_reg);

    always_comb
    begin
        res = '0;
        priority if (use_cpu)
        begin
            res.found       = 1'b1;
            res.chosen_node = PORT_ID_W'(take_cpu ? cand_id : cpu_id_reg);
        end
        else if (take_any || any_valid_reg)
        begin
            res.found       = 1'b1;
            res.chosen_node = PORT_ID_W'(take_any ? cand_id : any_id_reg);
        end
        else
        begin
            res = '0;
        end
    end

    assign res_valid     = s1_fire && s1_item_reg.last;
    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_fire);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            any_valid_reg <= 1'b0;
            cpu_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            any_valid_reg <= any_valid_next;
            cpu_valid_reg <= cpu_valid_next;
        end
    end

    // Payload: input word and tracker contents
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        any_id_reg    <= any_id_next;
        any_score_reg <= any_score_next;
        any_ready_reg <= any_ready_next;
        any_local_reg <= any_local_next;
        cpu_id_reg    <= cpu_id_next;
        cpu_score_reg <= cpu_score_next;
        cpu_local_reg <= cpu_local_next;
    end

    // A result appears only when the output slot can take it
    a_res_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_take)
        else $error("result issued while output slot full");

    // Both trackers are empty once a round closes
    a_round_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_item_reg.last) |=> (!any_valid_reg && !cpu_valid_reg))
        else $error("tracker survived end of round");

    // A result with no winner reports id zero
    a_nil_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.found) |-> (res.chosen_node == '0))
        else $error("nil result with nonzero id");

    // A held word that is not consumed stays in place
    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && s1_item_reg.last))
        else $error("stalled word lost");

endmodule

// ----- design/lns_out_reg.sv -----
// Output register of the node selector: holds one result word until the sink takes it.
// Depends on lns_pkg.
module lns_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  lns_pkg::result_t res,
    output logic             res_take,
    output logic             out_valid,
    output lns_pkg::result_t out_result,
    input  logic             out_ready
);
    import lns_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_result_reg;

    // Slot is free when empty or being drained this cycle
    assign res_take       = !out_valid_reg || out_ready;
    assign out_valid_next = res_valid || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a new word
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_result_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// ----- tb/least_utilized_node_selector_tb.sv -----
// Self-checking testbench for least_utilized_node_selector: directed rounds, then random rounds.
// Predicts each round's pick with its own rank trackers and checks every result word in order.
// Depends on lns_pkg, lns_node_if, lns_result_if and the selector RTL.
`timescale 1ns / 100ps

module least_utilized_node_selector_tb;
    import lns_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 125;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;

    // One directed row: node word, then a typed expectation where it is obvious.
    typedef struct packed {
        item_t   node;
        logic    typed;
        result_t want;
    } step_t;

    // One rank tracker; the non-GPU tracker keeps ready set.
    typedef struct packed {
        logic  valid;
        id_t   id;
        util_t score;
        logic  ready;
        logic  is_loc;
    } best_t;

    logic clk = 1'b0;
    logic rst_n;

    lns_node_if   node_ch();
    lns_result_if result_ch();

    logic                 cfg_we;
    cfg_index_t           cfg_index;
    logic [CFG_DW-1:0]    cfg_wdata;

    // Predictor state and register shadow
    cfg_t    regs;
    best_t   best_any;
    best_t   best_cpu;
    result_t pending_picks[$];
    result_t head_pick;

    int   mismatches    = 0;
    int   cycle_count   = 0;
    logic calm          = 1'b0;
    logic hold_off_req  = 1'b0;
    int   hold_off_left = 0;

    step_t directed [0:17];

    least_utilized_node_selector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .node_in   (node_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // True when the candidate ranks ahead of the held best.
    function automatic logic ranks_ahead(input logic cr, input util_t cs, input logic cl,
                                         input id_t cid, input best_t b);
        if (cr != b.ready)
            return cr;
        if (cs != b.score)
            return cs < b.score;
        if (cl != b.is_loc)
            return cl;
        return cid < b.id;
    endfunction

    // Fold one node into both trackers; on the last node give the pick and clear.
    function automatic logic track_node(input item_t n, output result_t pick);
        id_t   nid;
        util_t score;
        logic  is_loc;
        nid    = n.node_id;
        is_loc = (nid == regs.local_node_id);
        score  = (n.utilization < regs.load_floor) ? '0 : n.utilization;
        pick   = '0;
        if (n.node_alive && n.feasible && !(is_loc && regs.skip_local))
        begin
            if ((n.available || !regs.avail_only) &&
                (!best_any.valid || ranks_ahead(n.available, score, is_loc, nid, best_any)))
                best_any = {1'b1, nid, score, n.available, is_loc};
            if (n.available && !n.node_has_gpu &&
                (!best_cpu.valid || ranks_ahead(1'b1, score, is_loc, nid, best_cpu)))
                best_cpu = {1'b1, nid, score, 1'b1, is_loc};
        end
        if (!n.last)
            return 1'b0;
        if (regs.avoid_gpu_nodes && !n.gpu_request && best_cpu.valid)
            pick = {best_cpu.id, 1'b1};
        else if (best_any.valid)
            pick = {best_any.id, 1'b1};
        best_any.valid = 1'b0;
        best_cpu.valid = 1'b0;
        return 1'b1;
    endfunction

    // Offer one node word, with a random gap ahead of it, and record the pick it causes.
    task automatic send_node(input item_t n, input logic typed, input result_t want);
        result_t pick;
        @(negedge clk);
        if (!calm && $urandom_range(99) < 25)
        begin
            node_ch.valid = 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge clk);
        end
        node_ch.valid = 1'b1;
        node_ch.item  = n;
        do @(posedge clk); while (!node_ch.ready);
        if (track_node(n, pick))
            pending_picks.insert(pending_picks.size(), typed ? want : pick);
    endtask

    // Drop valid, wait for every pick, then let the pipeline empty.
    task automatic drain_picks();
        @(negedge clk);
        node_ch.valid = 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; consecutive calls keep the write enable high.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DW-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        case (idx)
            CFG_LOAD_FLOOR:      regs.load_floor      = value;
            CFG_SKIP_LOCAL:      regs.skip_local      = value[0];
            CFG_AVAIL_ONLY:      regs.avail_only      = value[0];
            CFG_AVOID_GPU_NODES: regs.avoid_gpu_nodes = value[0];
            CFG_LOCAL_NODE_ID:   regs.local_node_id   = value[15:0];
            default: ;
        endcase
    endtask

    // Result side: random stalls, one long hold-off on request, none while calm.
    always @(negedge clk)
    begin
        if (hold_off_left != 0)
        begin
            result_ch.ready = 1'b0;
            hold_off_left   = hold_off_left - 1;
        end
        else if (hold_off_req)
        begin
            hold_off_req    = 1'b0;
            hold_off_left   = HOLD_CYCLES - 1;
            result_ch.ready = 1'b0;
        end
        else
            result_ch.ready = calm || ($urandom_range(99) >= 28);
    end

    // Compare each accepted result word with the oldest pick.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_picks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cycle %0d: unexpected word chosen_node=%h found=%b", cycle_count,
                             result_ch.result.chosen_node, result_ch.result.found);
            end
            else
            begin
                head_pick = pending_picks.pop_front();
                if (result_ch.result.chosen_node !== head_pick.chosen_node ||
                    result_ch.result.found !== head_pick.found)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cycle %0d: chosen_node exp %h got %h, found exp %b got %b",
                                 cycle_count, head_pick.chosen_node,
                                 result_ch.result.chosen_node, head_pick.found,
                                 result_ch.result.found);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("least_utilized_node_selector_tb failed");
            $finish;
        end
    end

    initial
    begin
        item_t             n;
        int                len;
        int                phase_items;
        logic              noise;
        logic              greq;
        logic [CFG_DW-1:0] thr;
        logic              spill;
        logic              need_avail;
        logic              avoid;
        logic [15:0]       lid;

        node_ch.valid   = 1'b0;
        node_ch.item    = '0;
        result_ch.ready = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_LOAD_FLOOR;
        cfg_wdata       = '0;
        rst_n           = 1'b0;
        regs            = '0;
        best_any        = '0;
        best_cpu        = '0;

        // Columns: id, {alive, feasible, available, has_gpu, gpu_request}, utilization,
        // last, typed, expected chosen_node, expected found. Reset registers apply.
        directed = '{
            {16'h0001, 5'b01110, 17'h00000, 1'b1, 1'b1, 16'h0000, 1'b0}, // dead only: none
            {16'hFFFF, 5'b11111, 17'h1FFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1}, // all ones
            {16'h0000, 5'b11100, 17'h00000, 1'b1, 1'b1, 16'h0000, 1'b1}, // all zeros, local
            {16'h0010, 5'b10100, 17'h00000, 1'b0, 1'b0, 16'h0000, 1'b0}, // infeasible
            {16'h0011, 5'b11000, 17'h00000, 1'b0, 1'b0, 16'h0000, 1'b0}, // busy, low load
            {16'h0012, 5'b11100, 17'h10000, 1'b0, 1'b0, 16'h0000, 1'b0}, // ready, full load
            {16'h0013, 5'b01100, 17'h00000, 1'b1, 1'b0, 16'h0000, 1'b0},
            {16'h0009, 5'b11100, 17'd100,   1'b0, 1'b0, 16'h0000, 1'b0}, // score tie
            {16'h0003, 5'b11100, 17'd100,   1'b0, 1'b0, 16'h0000, 1'b0}, // lower id
            {16'h0003, 5'b11100, 17'd100,   1'b0, 1'b0, 16'h0000, 1'b0}, // repeated id
            {16'h0000, 5'b11100, 17'd100,   1'b1, 1'b0, 16'h0000, 1'b0}, // local wins tie
            {16'h0020, 5'b11100, 17'd5,     1'b0, 1'b0, 16'h0000, 1'b0},
            {16'h0021, 5'b11111, 17'd7,     1'b0, 1'b0, 16'h0000, 1'b0}, // GPU request
            {16'h0022, 5'b11110, 17'd3,     1'b1, 1'b0, 16'h0000, 1'b0}, // last flag rules
            {16'hABCD, 5'b11001, 17'h0FFFF, 1'b1, 1'b1, 16'hABCD, 1'b1}, // busy only
            {16'h5555, 5'b11110, 17'h1FFFF, 1'b0, 1'b0, 16'h0000, 1'b0}, // above one
            {16'hAAAA, 5'b00000, 17'h00000, 1'b1, 1'b0, 16'h0000, 1'b0},
            {16'h8000, 5'b11101, 17'h1FFFF, 1'b1, 1'b1, 16'h8000, 1'b1}
        };

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_node(directed[i].node, directed[i].typed, directed[i].want);

        for (int phase = 0; phase < 6; phase++)
        begin
            drain_picks();

            // Pick a register setting; the first three phases hit the extremes.
            case (phase)
                0:
                begin
                    thr = 17'h00000; spill = 1'b0; need_avail = 1'b0; avoid = 1'b0;
                    lid = 16'($urandom_range(15));
                end
                1:
                begin
                    thr = 17'h10000; spill = 1'b1; need_avail = 1'b1; avoid = 1'b1;
                    lid = 16'hFFFF;
                end
                2:
                begin
                    thr = 17'h1FFFF; spill = 1'b0; need_avail = 1'b1; avoid = 1'b1;
                    lid = 16'h0000;
                end
                3:
                begin
                    thr = 17'($urandom_range(17'h10000)); spill = 1'b1;
                    need_avail = 1'b0; avoid = 1'b0; lid = 16'($urandom);
                end
                default:
                begin
                    thr = 17'($urandom_range(17'h10000)); spill = 1'($urandom_range(1));
                    need_avail = 1'($urandom_range(1)); avoid = 1'($urandom_range(1));
                    lid = 16'($urandom);
                end
            endcase

            // Upper bits of narrow registers carry noise that must be dropped.
            write_reg(CFG_LOAD_FLOOR, thr);
            write_reg(CFG_SKIP_LOCAL, (17'($urandom) & 17'h1FFFE) | 17'(spill));
            write_reg(CFG_AVAIL_ONLY, (17'($urandom) & 17'h1FFFE) | 17'(need_avail));
            write_reg(CFG_AVOID_GPU_NODES, (17'($urandom) & 17'h1FFFE) | 17'(avoid));
            write_reg(CFG_LOCAL_NODE_ID, {1'($urandom_range(1)), lid});
            @(negedge clk);
            cfg_we = 1'b0;

            calm = (phase == 3);
            if (phase == 2)
                hold_off_req = 1'b1;

            // Rounds of node words, mostly well formed, some dead or infeasible.
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                len   = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1);
                noise = ($urandom_range(9) == 0);
                greq  = 1'($urandom_range(1));
                for (int k = 0; k < len; k++)
                begin
                    case ($urandom_range(9))
                        0, 1, 2:    n.node_id = regs.local_node_id;
                        3, 4, 5, 6: n.node_id = regs.local_node_id + 16'($urandom_range(6, 1));
                        default:    n.node_id = 16'($urandom);
                    endcase
                    n.node_alive   = noise ? ($urandom_range(99) < 30) : ($urandom_range(99) < 90);
                    n.feasible     = noise ? ($urandom_range(99) < 30) : ($urandom_range(99) < 90);
                    n.available    = ($urandom_range(99) < 65);
                    n.node_has_gpu = 1'($urandom_range(1));
                    n.gpu_request  = ($urandom_range(99) < 85) ? greq : 1'($urandom_range(1));
                    case ($urandom_range(9))
                        0, 1, 2: n.utilization = regs.load_floor + 17'($urandom_range(2))
                                                 - 17'd1;
                        3, 4, 5: n.utilization = {2'($urandom_range(2)), 15'h0000};
                        6, 7:    n.utilization = 17'($urandom_range(17'h1FFFF));
                        default: n.utilization = 17'($urandom_range(255));
                    endcase
                    n.last = (k == len - 1);
                    send_node(n, 1'b0, '0);
                    phase_items++;
                end
            end
        end

        drain_picks();
        calm = 1'b0;

        if (mismatches == 0)
            $display("least_utilized_node_selector_tb passed");
        else
            $display("least_utilized_node_selector_tb failed");
        $finish;
    end

endmodule
